// ===== rtl/core/mf3_pkg.sv =====
// mf3_pkg: shared constants, types and compare helpers of the 3x3 median filter
// no dependencies; imported by every module of the filter core
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MIN_DIM      = 3;
	localparam int PIX_W        = 8;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = $clog2(MAX_HEIGHT);
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 2;
	localparam int WIN_SIZE     = 9;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [2:0] pix_row_t;

	// position info for one request
	typedef struct packed {
		logic             emit;
		logic             frame_end;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] addr;
	} scan_info_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// element 0 smallest, element 2 largest
	function automatic pix_row_t sort3(input pix_row_t r);
		pix_row_t s;
		s[0] = min2(min2(r[0], r[1]), r[2]);
		s[1] = med3(r[0], r[1], r[2]);
		s[2] = max2(max2(r[0], r[1]), r[2]);
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/median_filter_3x3_core.sv =====
// median_filter_3x3_core: streaming 3x3 median over raster-order 8-bit pixels
// an interior result is registered through stage 1, the window, the row sort and the output register
// throughput: one pixel per cycle unless the output stalls, set by one read and one write per line store each cycle
// reset: counters clear, size registers load 640 x 480, window clears; line stores hold junk
// depends on mf3_pkg, mf3_scan_ctrl, mf3_line_buf
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3_core import mf3_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [PIX_W-1:0]      pixel,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [PIX_W-1:0]           median,
	output logic [ROW_W-1:0]           out_row,
	output logic [COL_W-1:0]           out_col,
	output logic                       frame_end
);

	// whole pipe moves together unless the result register is held
	logic       adv;
	logic       in_acc;
	scan_info_t scan_info;

	// stage 1: pixel and position, line store read in flight
	logic       v_s1;
	pix_t       px_s1;
	scan_info_t info_s1;
	pix_t       rd_upper;
	pix_t       rd_middle;

	// stage 2: sliding window (persistent state)
	logic       v_s2;
	pix_t       win_q [WIN_SIZE];
	scan_info_t info_s2;

	// stage 3: each window row sorted
	logic       v_s3;
	pix_row_t   rows_s3 [3];
	scan_info_t info_s3;

	// output register
	logic             out_valid_q;
	pix_t             median_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             frame_end_q;

	pix_t     lo_sel;
	pix_t     md_sel;
	pix_t     hi_sel;
	pix_row_t win_row [3];

	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign in_acc   = in_valid && adv;

	mf3_scan_ctrl u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (in_acc),
		.info      (scan_info)
	);

	// upper store gets the old middle value once its read has returned
	mf3_line_buf u_lbuf (
		.clk       (clk),
		.rd_en     (in_acc),
		.rd_addr   (scan_info.addr),
		.mid_wdata (pixel),
		.up_we     (adv && v_s1),
		.up_waddr  (info_s1.addr),
		.up_wdata  (rd_middle),
		.rd_upper  (rd_upper),
		.rd_middle (rd_middle)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && info_s3.emit;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= pixel;
			info_s1 <= scan_info;
		end
	end

	// window shift: column 2 of each row takes the new column (top, middle, pixel)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_SIZE; i++)
				win_q[i] <= '0;
		end else if (adv && v_s1) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= rd_upper;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= rd_middle;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1)
			info_s2 <= info_s1;
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_row[k][0] = win_q[3*k];
			win_row[k][1] = win_q[3*k+1];
			win_row[k][2] = win_q[3*k+2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			for (int k = 0; k < 3; k++)
				rows_s3[k] <= sort3(win_row[k]);
			info_s3 <= info_s2;
		end
	end

	// median of nine = median of (largest row min, middle row median, smallest row max)
	always_comb begin
		lo_sel = max2(max2(rows_s3[0][0], rows_s3[1][0]), rows_s3[2][0]);
		md_sel = med3(rows_s3[0][1], rows_s3[1][1], rows_s3[2][1]);
		hi_sel = min2(min2(rows_s3[0][2], rows_s3[1][2]), rows_s3[2][2]);
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			median_q    <= med3(lo_sel, md_sel, hi_sel);
			out_row_q   <= info_s3.row;
			out_col_q   <= info_s3.col;
			frame_end_q <= info_s3.frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign frame_end = frame_end_q;

`ifndef SYNTH
	// newest window column holds the pixel that just left stage 1
	a_win_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && v_s1) |=> (win_q[8] == $past(px_s1)))
		else $error("window did not take the stage 1 pixel");

	// upper store write never collides with the read of the next request
	a_lbuf_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && v_s1) |-> (scan_info.addr != info_s1.addr))
		else $error("line store read and write at the same column");

	// results only for interior positions
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_row_q != '0 && out_col_q != '0))
		else $error("result emitted for a border position");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mf3_scan_ctrl.sv =====
// mf3_scan_ctrl: frame size registers and raster column/row counters
// depends on mf3_pkg
`timescale 1ns / 1ps
`default_nettype none

module mf3_scan_ctrl import mf3_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  step,
	output scan_info_t                 info
);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;

	logic [WIDTH_REG_W-1:0]  w_use;
	logic [HEIGHT_REG_W-1:0] h_use;
	logic [WIDTH_REG_W-1:0]  col_inc;
	logic [HEIGHT_REG_W-1:0] row_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to the supported range
	always_comb begin
		if (width_q < WIDTH_REG_W'(MIN_DIM))
			w_use = WIDTH_REG_W'(MIN_DIM);
		else if (width_q > WIDTH_REG_W'(MAX_WIDTH))
			w_use = WIDTH_REG_W'(MAX_WIDTH);
		else
			w_use = width_q;
		if (height_q < HEIGHT_REG_W'(MIN_DIM))
			h_use = HEIGHT_REG_W'(MIN_DIM);
		else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT))
			h_use = HEIGHT_REG_W'(MAX_HEIGHT);
		else
			h_use = height_q;
	end

	assign col_inc = {1'b0, col_q} + WIDTH_REG_W'(1);
	assign row_inc = {1'b0, row_q} + HEIGHT_REG_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_inc >= w_use) begin
				col_q <= '0;
				row_q <= (row_inc >= h_use) ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_comb begin
		info.emit      = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
		info.frame_end = ({1'b0, row_q} == h_use - HEIGHT_REG_W'(1)) &&
		                 ({1'b0, col_q} == w_use - WIDTH_REG_W'(1));
		info.row       = row_q - ROW_W'(1);
		info.col       = col_q - COL_W'(1);
		info.addr      = col_q;
	end

endmodule

`default_nettype wire

// ===== rtl/core/mf3_line_buf.sv =====
// mf3_line_buf: the two line stores holding the previous two rows
// depends on mf3_pkg
`timescale 1ns / 1ps
`default_nettype none

module mf3_line_buf import mf3_pkg::*; (
	input  wire logic             clk,
	input  wire logic             rd_en,
	input  wire logic [COL_W-1:0] rd_addr,
	input  wire pix_t             mid_wdata,
	input  wire logic             up_we,
	input  wire logic [COL_W-1:0] up_waddr,
	input  wire pix_t             up_wdata,
	output pix_t                  rd_upper,
	output pix_t                  rd_middle
);

	pix_t upper_mem  [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];

	// read-before-write on the middle store at the same column
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_upper            <= upper_mem[rd_addr];
			rd_middle           <= middle_mem[rd_addr];
			middle_mem[rd_addr] <= mid_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (up_we)
			upper_mem[up_waddr] <= up_wdata;
	end

endmodule

`default_nettype wire

// ===== tb/median_filter_3x3_core_test.sv =====
// median_filter_3x3_core_test: self-checking bench for the streaming 3x3 median core
// drives frames through random valid/stall traffic and checks every median against
// a local window model or a typed result; depends on mf3_pkg and median_filter_3x3_core
`timescale 1ns / 1ps

module median_filter_3x3_core_test;
	import mf3_pkg::*;

	localparam int LIMIT_CYCLES  = 3_000_000;
	localparam int HOLD_CYCLES   = 200;   // long output hold-off to back the core up
	localparam int HOLD_AFTER    = 40;    // medians seen before the hold-off starts
	localparam int DRAIN_CYCLES  = 8;     // time for border pixels still in the core to clear
	localparam int RANDOM_PIXELS = 1150;
	localparam int SHOW_MAX      = 10;
	localparam int PLAN_LEN      = 27;

	// one median as the core reports it
	typedef struct packed {
		pix_t             med;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             fe;
	} median_t;

	// one directed request: pixel plus an optional hand-written result
	typedef struct packed {
		pix_t    px;
		logic    typed;
		median_t want;
	} plan_row_t;

	// flavor of pixel content in a random phase
	typedef enum int {
		MIX_UNIFORM,
		MIX_EXTREME,
		MIX_BAND,
		MIX_SPIKES
	} pix_mix_t;

	localparam median_t NO_RESULT = '0;

	// three 3x3 frames (size registers written below the floor, so clamped to 3x3)
	// each frame yields exactly one median at row 1, col 1 on its last pixel
	localparam plan_row_t [0:PLAN_LEN-1] DIRECTED = {
		// all at full scale
		{8'd255, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT},
		{8'd255, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT},
		{8'd255, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT},
		{8'd255, 1'b1, 8'd255, 12'd1, 10'd1, 1'b1},
		// four zeros, four full scale, one mid value: the mid value wins
		{8'd0, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT}, {8'd0, 1'b0, NO_RESULT},
		{8'd255, 1'b0, NO_RESULT}, {8'd128, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT},
		{8'd0, 1'b0, NO_RESULT}, {8'd255, 1'b0, NO_RESULT},
		{8'd0, 1'b1, 8'd128, 12'd1, 10'd1, 1'b1},
		// one through nine scrambled
		{8'd9, 1'b0, NO_RESULT}, {8'd1, 1'b0, NO_RESULT}, {8'd8, 1'b0, NO_RESULT},
		{8'd2, 1'b0, NO_RESULT}, {8'd7, 1'b0, NO_RESULT}, {8'd3, 1'b0, NO_RESULT},
		{8'd6, 1'b0, NO_RESULT}, {8'd4, 1'b0, NO_RESULT},
		{8'd5, 1'b1, 8'd5, 12'd1, 10'd1, 1'b1}
	};

	// block ports, all inputs known from time zero
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_stall;
	pix_t                  pixel     = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pix_t                  median;
	logic [ROW_W-1:0]      out_row;
	logic [COL_W-1:0]      out_col;
	logic                  frame_end;

	// window model state
	logic [WIDTH_REG_W-1:0]  size_w_reg = WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] size_h_reg = HEIGHT_RESET;
	pix_t                    store_upper [MAX_WIDTH];
	pix_t                    store_middle [MAX_WIDTH];
	pix_t                    win [WIN_SIZE];
	int                      col_cnt = 0;
	int                      row_cnt = 0;

	// scoreboard and bookkeeping
	median_t medians_due [$];
	median_t oldest;
	int      errors       = 0;
	int      results_seen = 0;
	int      frames_seen  = 0;
	int      pixels_sent  = 0;
	int      writes_done  = 0;
	int      cycle_count  = 0;
	bit      quiet        = 1'b0;
	int      stall_left   = 0;
	bit      hold_done    = 1'b0;
	int      burst;

	median_filter_3x3_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.median    (median),
		.out_row   (out_row),
		.out_col   (out_col),
		.frame_end (frame_end)
	);

	always #5 clk = ~clk;

	// hard stop, counts every cycle of the run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d medians still due",
				cycle_count, medians_due.size());
			$display("median_filter_3x3_core: mismatch");
			$finish;
		end
	end

	// idle length: mostly none, some short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// sizes in use, registers clamped to the legal range
	function automatic int used_width();
		int v;
		v = size_w_reg;
		return (v < MIN_DIM) ? MIN_DIM : (v > MAX_WIDTH) ? MAX_WIDTH : v;
	endfunction

	function automatic int used_height();
		int v;
		v = size_h_reg;
		return (v < MIN_DIM) ? MIN_DIM : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
	endfunction

	// fifth smallest of the window, found by rank: fewer than five below and
	// at least five at or below
	function automatic pix_t window_median();
		int   i, j, lt, le;
		pix_t pick;
		pick = '0;
		for (i = 0; i < WIN_SIZE; i++) begin
			lt = 0;
			le = 0;
			for (j = 0; j < WIN_SIZE; j++) begin
				if (win[j] < win[i])
					lt++;
				if (win[j] <= win[i])
					le++;
			end
			if (lt <= 4 && le >= 5)
				pick = win[i];
		end
		return pick;
	endfunction

	// advance the model by one accepted pixel
	task automatic advance_model(input pix_t p, output bit emitted, output median_t res);
		int   w, h, c, k;
		pix_t above, mid;
		w = used_width();
		h = used_height();
		c = col_cnt % MAX_WIDTH;
		above = store_upper[c];
		mid = store_middle[c];
		store_upper[c] = mid;
		store_middle[c] = p;
		// slide each window row left, new column enters on the right
		for (k = 0; k < WIN_SIZE; k++)
			if (k % 3 != 2)
				win[k] = win[k + 1];
		win[2] = above;
		win[5] = mid;
		win[8] = p;
		// centre sits one row up and one column left of the newest pixel
		emitted = (row_cnt >= 2 && c >= 2);
		res.med = window_median();
		res.row = ROW_W'(row_cnt - 1);
		res.col = COL_W'(c - 1);
		res.fe = (row_cnt == h - 1 && c == w - 1);
		// counters wrap against the bounds in use now, even if they shrank mid-frame
		c++;
		if (c >= w) begin
			c = 0;
			row_cnt++;
			if (row_cnt >= h)
				row_cnt = 0;
		end
		col_cnt = c;
	endtask

	function automatic pix_t make_pixel(pix_mix_t mix);
		case (mix)
			MIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
			MIX_BAND:    return 8'($urandom_range(120, 136));
			MIX_SPIKES:  return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd200;
			default:     return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// offer one pixel, hold it until taken, then log what it should produce
	// a typed result, where given, replaces the model's
	task automatic push_pixel(input pix_t p, input bit typed, input median_t want);
		int      gap;
		bit      emitted;
		median_t res;
		gap = quiet ? 0 : idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (in_stall);
		advance_model(p, emitted, res);
		if (typed)
			medians_due.push_back(want);
		else if (emitted)
			medians_due.push_back(res);
		pixels_sent++;
	endtask

	// stop offering, let every due median land, then give border pixels
	// still in the pipe time to clear
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (medians_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_IMAGE_WIDTH:  size_w_reg = WIDTH_REG_W'(val);
			CFG_IMAGE_HEIGHT: size_h_reg = HEIGHT_REG_W'(val);
			default: ;
		endcase
		writes_done++;
	endtask

	// run on to the next frame boundary
	task automatic finish_frame(input pix_mix_t mix);
		while (col_cnt != 0 || row_cnt != 0)
			push_pixel(make_pixel(mix), 1'b0, NO_RESULT);
	endtask

	// receiver: random stall bursts, plus one long hold-off once the stream is busy
	// and a pixel is on offer, so the core backs up into its input
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen >= HOLD_AFTER && in_valid) begin
			hold_done = 1'b1;
			stall_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			burst = quiet ? 0 : idle_len();
			if (burst > 0)
				stall_left = burst - 1;
			out_stall <= (burst > 0);
		end
	end

	// compare each taken median with the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (frame_end)
				frames_seen++;
			if (medians_due.size() == 0) begin
				errors++;
				if (errors <= SHOW_MAX)
					$display("%0t: unexpected median %0d row %0d col %0d end %0b",
						$realtime, median, out_row, out_col, frame_end);
			end else begin
				oldest = medians_due.pop_front();
				if (median !== oldest.med || out_row !== oldest.row ||
						out_col !== oldest.col || frame_end !== oldest.fe) begin
					errors++;
					if (errors <= SHOW_MAX)
						$display({"%0t: bad median, want %0d row %0d col %0d end %0b,",
							" got %0d row %0d col %0d end %0b"}, $realtime,
							oldest.med, oldest.row, oldest.col, oldest.fe,
							median, out_row, out_col, frame_end);
				end
			end
		end
	end

	initial begin
		int       i, w_val, h_val, skip, count, frame_px, random_pixels;
		bit       mid_frame;
		pix_mix_t mix;

		foreach (win[k])
			win[k] = '0;
		random_pixels = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// power-up size 640 x 480: part of the first row
		repeat (100) push_pixel(make_pixel(MIX_UNIFORM), 1'b0, NO_RESULT);

		// shrink both sizes mid-frame: the column count is already past the new
		// width, so the next pixel ends the row and two short rows end the frame
		settle();
		write_reg(CFG_IMAGE_WIDTH, 5);
		write_reg(CFG_IMAGE_HEIGHT, 3);
		finish_frame(MIX_UNIFORM);

		// directed frames, registers below the floor clamp to 3x3
		settle();
		write_reg(CFG_IMAGE_WIDTH, 0);
		write_reg(CFG_IMAGE_HEIGHT, 2);
		for (i = 0; i < PLAN_LEN; i++)
			push_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);

		// random phases of small frames; a phase may stop mid-frame, and then
		// the width may only stay or shrink so no stale line store entry is read
		while (random_pixels < RANDOM_PIXELS) begin
			settle();
			mid_frame = (col_cnt != 0 || row_cnt != 0);
			if (mid_frame)
				w_val = $urandom_range(0, used_width());
			else if ($urandom_range(0, 9) == 0)
				w_val = $urandom_range(25, 120);
			else
				w_val = $urandom_range(0, 24);
			h_val = (w_val > 24) ? $urandom_range(0, 4) : $urandom_range(0, 10);
			skip = $urandom_range(0, 3);
			// junk in the data bits above the width register is dropped
			if (skip != 1)
				write_reg(CFG_IMAGE_WIDTH, w_val | ($urandom_range(0, 3) << WIDTH_REG_W));
			if (skip != 2)
				write_reg(CFG_IMAGE_HEIGHT, h_val);
			quiet = ($urandom_range(0, 4) == 0);
			mix = pix_mix_t'($urandom_range(0, 3));
			frame_px = used_width() * used_height();
			if (!mid_frame && $urandom_range(0, 2) != 0)
				count = frame_px * $urandom_range(1, 2);
			else
				count = $urandom_range(1, frame_px);
			if (count > RANDOM_PIXELS - random_pixels)
				count = RANDOM_PIXELS - random_pixels;
			repeat (count) push_pixel(make_pixel(mix), 1'b0, NO_RESULT);
			random_pixels += count;
		end

		settle();
		$display("run covered %0d pixels, %0d medians and %0d frame ends over %0d register writes",
			pixels_sent, results_seen, frames_seen, writes_done);
		$display("sizes from the clamped 3x3 floor to 120 wide, mid-frame resizes, %0d bad results",
			errors);
		if (errors == 0)
			$display("median_filter_3x3_core: match");
		else
			$display("median_filter_3x3_core: mismatch");
		$finish;
	end

endmodule
